### hw/rtl/protected_region_table_top_defines.svh
// Assertion macros for the protected region table checker.
// Depends on nothing; the using module supplies clk and rst.
`ifndef PROTECTED_REGION_TABLE_TOP_DEFINES_SVH
`define PROTECTED_REGION_TABLE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/prt_pkg.sv
// Shared constants, types and codes for the protected region table.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package prt_pkg;

  // Table sizes.
  localparam int MAX_REGION_ENTRIES = 16;
  localparam int MAX_DESC_ENTRIES   = 16;

  // Field widths.
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 8;
  localparam int KIB_W     = 23;
  localparam int KIB_SHIFT = 10;
  localparam int BYTE_W    = KIB_W + KIB_SHIFT;
  localparam int IDX_W     = 4;
  localparam int USED_W    = 5;

  // Derived address and count widths.
  localparam int REG_AW  = (MAX_REGION_ENTRIES > 1) ? $clog2(MAX_REGION_ENTRIES) : 1;
  localparam int REG_CW  = $clog2(MAX_REGION_ENTRIES + 1);
  localparam int DESC_AW = (MAX_DESC_ENTRIES > 1) ? $clog2(MAX_DESC_ENTRIES) : 1;
  localparam int DESC_CW = $clog2(MAX_DESC_ENTRIES + 1);
  localparam int SCAN_CW = (REG_CW > DESC_CW) ? REG_CW : DESC_CW;

  typedef logic [REG_CW-1:0]  reg_cnt_t;
  typedef logic [DESC_CW-1:0] desc_cnt_t;
  typedef logic [SCAN_CW-1:0] scan_cnt_t;
  typedef logic [BYTE_W-1:0]  wide_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [USED_W-1:0]  used_t;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_ADD    = 2'd2,
    CMD_REMOVE = 2'd3
  } command_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_ORDER    = 3'd2,
    ST_RESERVED = 3'd3,
    ST_NOFIT    = 3'd4,
    ST_OVERLAP  = 3'd5,
    ST_NOTFOUND = 3'd6,
    ST_DESCFULL = 3'd7
  } status_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DESC_WRITE,
    OP_DESC_CLEAR,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_SHIFT_INIT,
    OP_APPEND,
    OP_DROP,
    OP_RESPOND
  } op_t;

  // Which table a scan walks and what each visited entry is tested for.
  typedef enum logic [1:0] {
    SEL_DESC,
    SEL_OVERLAP,
    SEL_TAG,
    SEL_SHIFT
  } sel_t;

  // One input transfer.
  typedef struct packed {
    command_t              command;
    logic [TAG_W-1:0]      region_tag;
    logic [ADDR_W-1:0]     start_addr;
    logic [ADDR_W-1:0]     end_addr;
    logic                  desc_conventional;
    logic [KIB_W-1:0]      desc_low_kib;
    logic [KIB_W-1:0]      desc_high_kib;
  } request_t;

  // One result transfer.
  typedef struct packed {
    status_t status;
    idx_t    conflict_index;
    used_t   regions_used;
  } result_t;

  // Stored region entry.
  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] limit_addr;
    logic [TAG_W-1:0]  tag;
  } region_t;

  // Stored memory descriptor.
  typedef struct packed {
    logic             conventional;
    logic [KIB_W-1:0] low_kib;
    logic [KIB_W-1:0] high_kib;
  } desc_t;

  // Controller to datapath.
  typedef struct packed {
    op_t     op;
    sel_t    sel;
    logic    set_status;
    status_t status;
    logic    idx_from_eval;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    command_t command;
    logic     desc_full;
    logic     reg_full;
    logic     bad_order;
    logic     desc_empty;
    logic     hit;
    logic     scan_done;
    logic     fits;
  } dp_stat_t;

endpackage

### hw/rtl/protected_region_table_top.sv
// Protected region table: a command is taken when start is high and busy
// is low (busy is also high while reset is held), and its single result is
// shown for exactly one cycle with done high; the receiver cannot stall, so
// it must capture the result in that cycle. One command is handled at a
// time. Each table has one read port and is walked one entry per cycle.
// A load or clear, and an add refused as full or out of order, goes
// straight from dispatch to the response; an add that passes walks the
// D descriptors and then the R stored regions, and stops early on a
// conflict or when no descriptor fits; for a remove, the search and the
// compaction together visit each stored region once. There is no
// clearing pass after reset.
// Depends on prt_pkg, prt_ctrl and prt_dpath.
`timescale 1ns / 1ps

module protected_region_table_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  prt_pkg::request_t  request,
  output logic               busy,
  output logic               done,
  output prt_pkg::result_t   result
);

  prt_pkg::ctrl_cmd_t ctrl;
  prt_pkg::dp_stat_t  stat;

  // Sequencer.
  prt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Tables, scan engine and result register.
  prt_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctrl    (ctrl),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule

### hw/rtl/prt_ctrl.sv
// Controller state machine for the protected region table.
// Depends on prt_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module prt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  prt_pkg::dp_stat_t   stat,
  output logic                busy,
  output prt_pkg::ctrl_cmd_t  ctrl
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_DSCAN    = 7'b0000100,
    S_RSCAN    = 7'b0001000,
    S_FSCAN    = 7'b0010000,
    S_SHIFT    = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // No command is taken while reset is held.
  assign busy = rst || (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctrl = '{op: prt_pkg::OP_NONE, sel: prt_pkg::SEL_DESC, set_status: 1'b0,
             status: prt_pkg::ST_OK, idx_from_eval: 1'b0};
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.op    = prt_pkg::OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        ctrl.set_status = 1'b1;
        state_next      = S_RESP;
        case (stat.command)
          prt_pkg::CMD_LOAD: begin
            if (stat.desc_full) begin
              ctrl.status = prt_pkg::ST_DESCFULL;
            end else begin
              ctrl.op = prt_pkg::OP_DESC_WRITE;
            end
          end
          prt_pkg::CMD_CLEAR: begin
            ctrl.op = prt_pkg::OP_DESC_CLEAR;
          end
          prt_pkg::CMD_ADD: begin
            if (stat.reg_full) begin
              ctrl.status = prt_pkg::ST_FULL;
            end else if (stat.bad_order) begin
              ctrl.status = prt_pkg::ST_ORDER;
            end else begin
              ctrl.set_status = 1'b0;
              ctrl.op         = prt_pkg::OP_SCAN_INIT;
              state_next      = stat.desc_empty ? S_RSCAN : S_DSCAN;
            end
          end
          prt_pkg::CMD_REMOVE: begin
            ctrl.set_status = 1'b0;
            ctrl.op         = prt_pkg::OP_SCAN_INIT;
            state_next      = S_FSCAN;
          end
          default: begin
            ctrl.status = prt_pkg::ST_OK;
          end
        endcase
      end
      // Descriptor walk: a reserved overlap ends it at once.
      S_DSCAN: begin
        ctrl.sel = prt_pkg::SEL_DESC;
        if (stat.hit) begin
          ctrl.set_status    = 1'b1;
          ctrl.status        = prt_pkg::ST_RESERVED;
          ctrl.idx_from_eval = 1'b1;
          state_next         = S_RESP;
        end else if (stat.scan_done) begin
          if (stat.fits) begin
            ctrl.op    = prt_pkg::OP_SCAN_INIT;
            state_next = S_RSCAN;
          end else begin
            ctrl.set_status = 1'b1;
            ctrl.status     = prt_pkg::ST_NOFIT;
            state_next      = S_RESP;
          end
        end else begin
          ctrl.op = prt_pkg::OP_SCAN;
        end
      end
      // Region walk for overlap; append when none is found.
      S_RSCAN: begin
        ctrl.sel = prt_pkg::SEL_OVERLAP;
        if (stat.hit) begin
          ctrl.set_status    = 1'b1;
          ctrl.status        = prt_pkg::ST_OVERLAP;
          ctrl.idx_from_eval = 1'b1;
          state_next         = S_RESP;
        end else if (stat.scan_done) begin
          ctrl.op         = prt_pkg::OP_APPEND;
          ctrl.set_status = 1'b1;
          state_next      = S_RESP;
        end else begin
          ctrl.op = prt_pkg::OP_SCAN;
        end
      end
      // Region walk for the tag to remove.
      S_FSCAN: begin
        ctrl.sel = prt_pkg::SEL_TAG;
        if (stat.hit) begin
          ctrl.op    = prt_pkg::OP_SHIFT_INIT;
          state_next = S_SHIFT;
        end else if (stat.scan_done) begin
          ctrl.set_status = 1'b1;
          ctrl.status     = prt_pkg::ST_NOTFOUND;
          state_next      = S_RESP;
        end else begin
          ctrl.op = prt_pkg::OP_SCAN;
        end
      end
      // Move the entries above the removed one down by one place.
      S_SHIFT: begin
        ctrl.sel = prt_pkg::SEL_SHIFT;
        if (stat.scan_done) begin
          ctrl.op         = prt_pkg::OP_DROP;
          ctrl.set_status = 1'b1;
          state_next      = S_RESP;
        end else begin
          ctrl.op = prt_pkg::OP_SCAN;
        end
      end
      S_RESP: begin
        ctrl.op    = prt_pkg::OP_RESPOND;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/prt_dpath.sv
// Datapath for the protected region table: both tables, the scan engine
// and the result register. Depends on prt_pkg; commanded by prt_ctrl.
`timescale 1ns / 1ps

module prt_dpath (
  input  logic                clk,
  input  logic                rst,
  input  prt_pkg::request_t   request,
  input  prt_pkg::ctrl_cmd_t  ctrl,
  output prt_pkg::dp_stat_t   stat,
  output prt_pkg::result_t    result,
  output logic                done
);

  prt_pkg::request_t  req;
  prt_pkg::desc_cnt_t desc_count;
  prt_pkg::reg_cnt_t  reg_count;
  prt_pkg::scan_cnt_t ptr;
  prt_pkg::scan_cnt_t eval_idx;
  logic               eval_valid;
  logic               fits;
  prt_pkg::status_t   status_code;
  prt_pkg::scan_cnt_t conflict;

  prt_pkg::desc_t     desc_mem [prt_pkg::MAX_DESC_ENTRIES];
  prt_pkg::region_t   reg_mem  [prt_pkg::MAX_REGION_ENTRIES];
  prt_pkg::desc_t     desc_q;
  prt_pkg::region_t   reg_q;

  prt_pkg::scan_cnt_t limit;
  logic               issue;
  logic               scan_op;
  prt_pkg::wide_t     s_w, e_w, lo_w, hi_w;
  logic               start_in_desc, end_in_desc, desc_contain, desc_overlap;
  logic               reg_overlap, tag_match;
  logic               reg_we;
  logic [prt_pkg::REG_AW-1:0] reg_waddr;
  prt_pkg::region_t   reg_wdata;
  prt_pkg::scan_cnt_t shift_idx;

  // Scan limit and issue condition.
  assign limit   = (ctrl.sel == prt_pkg::SEL_DESC) ? prt_pkg::scan_cnt_t'(desc_count)
                                                   : prt_pkg::scan_cnt_t'(reg_count);
  assign issue   = (ptr < limit);
  assign scan_op = (ctrl.op == prt_pkg::OP_SCAN);

  // Descriptor tests at byte granularity, wide enough not to wrap.
  assign s_w  = prt_pkg::wide_t'(req.start_addr);
  assign e_w  = prt_pkg::wide_t'(req.end_addr);
  assign lo_w = prt_pkg::wide_t'(desc_q.low_kib) << prt_pkg::KIB_SHIFT;
  assign hi_w = prt_pkg::wide_t'(desc_q.high_kib) << prt_pkg::KIB_SHIFT;
  assign start_in_desc = (s_w >= lo_w) && (s_w < hi_w);
  assign end_in_desc   = (e_w > lo_w) && (e_w <= hi_w);
  assign desc_contain  = start_in_desc && end_in_desc;
  assign desc_overlap  = start_in_desc || end_in_desc || ((s_w < lo_w) && (e_w > hi_w));

  // Region tests; an end equal to a stored start counts as overlap.
  assign reg_overlap =
      ((req.start_addr >= reg_q.base_addr) && (req.start_addr < reg_q.limit_addr)) ||
      ((req.end_addr >= reg_q.base_addr) && (req.end_addr <= reg_q.limit_addr)) ||
      ((req.start_addr < reg_q.base_addr) && (req.end_addr > reg_q.base_addr));
  assign tag_match = (reg_q.tag == req.region_tag);

  // Status toward the controller.
  always_comb begin
    stat.command    = req.command;
    stat.desc_full  = (desc_count == prt_pkg::desc_cnt_t'(prt_pkg::MAX_DESC_ENTRIES));
    stat.reg_full   = (reg_count == prt_pkg::reg_cnt_t'(prt_pkg::MAX_REGION_ENTRIES));
    stat.bad_order  = (req.start_addr >= req.end_addr);
    stat.desc_empty = (desc_count == '0);
    stat.scan_done  = !issue && !eval_valid;
    stat.fits       = fits;
    case (ctrl.sel)
      prt_pkg::SEL_DESC:    stat.hit = eval_valid && !desc_q.conventional && desc_overlap;
      prt_pkg::SEL_OVERLAP: stat.hit = eval_valid && reg_overlap;
      prt_pkg::SEL_TAG:     stat.hit = eval_valid && tag_match;
      default:              stat.hit = 1'b0;
    endcase
  end

  // Region table write port: append at the end, or move an entry down.
  assign shift_idx = eval_idx - prt_pkg::scan_cnt_t'(1);
  always_comb begin
    reg_we    = 1'b0;
    reg_waddr = reg_count[prt_pkg::REG_AW-1:0];
    reg_wdata = '{base_addr: req.start_addr, limit_addr: req.end_addr,
                  tag: req.region_tag};
    if (ctrl.op == prt_pkg::OP_APPEND) begin
      reg_we = 1'b1;
    end else if (scan_op && (ctrl.sel == prt_pkg::SEL_SHIFT) && eval_valid) begin
      reg_we    = 1'b1;
      reg_waddr = shift_idx[prt_pkg::REG_AW-1:0];
      reg_wdata = reg_q;
    end
  end

  // Region table, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (reg_we) begin
      reg_mem[reg_waddr] <= reg_wdata;
    end
    reg_q <= reg_mem[ptr[prt_pkg::REG_AW-1:0]];
  end

  // Descriptor table, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.op == prt_pkg::OP_DESC_WRITE) begin
      desc_mem[desc_count[prt_pkg::DESC_AW-1:0]] <= '{
          conventional: req.desc_conventional,
          low_kib:      req.desc_low_kib,
          high_kib:     req.desc_high_kib};
    end
    desc_q <= desc_mem[ptr[prt_pkg::DESC_AW-1:0]];
  end

  // Request latch and scan index for the entry under test.
  always_ff @(posedge clk) begin
    if (ctrl.op == prt_pkg::OP_LATCH) begin
      req <= request;
    end
    if (scan_op && issue) begin
      eval_idx <= ptr;
    end
  end

  // Counts, scan pointer and fit flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_count <= '0;
      reg_count  <= '0;
      ptr        <= '0;
      eval_valid <= 1'b0;
      fits       <= 1'b0;
    end else begin
      case (ctrl.op)
        prt_pkg::OP_DESC_WRITE: begin
          desc_count <= desc_count + prt_pkg::desc_cnt_t'(1);
        end
        prt_pkg::OP_DESC_CLEAR: begin
          desc_count <= '0;
        end
        prt_pkg::OP_SCAN_INIT: begin
          ptr        <= '0;
          eval_valid <= 1'b0;
          fits       <= 1'b0;
        end
        prt_pkg::OP_SCAN: begin
          if (issue) begin
            ptr <= ptr + prt_pkg::scan_cnt_t'(1);
          end
          eval_valid <= issue;
          if ((ctrl.sel == prt_pkg::SEL_DESC) && eval_valid && desc_q.conventional &&
              desc_contain) begin
            fits <= 1'b1;
          end
        end
        prt_pkg::OP_SHIFT_INIT: begin
          ptr        <= eval_idx + prt_pkg::scan_cnt_t'(1);
          eval_valid <= 1'b0;
        end
        prt_pkg::OP_APPEND: begin
          reg_count <= reg_count + prt_pkg::reg_cnt_t'(1);
        end
        prt_pkg::OP_DROP: begin
          reg_count <= reg_count - prt_pkg::reg_cnt_t'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Status and conflict index of the command in progress.
  always_ff @(posedge clk) begin
    if (ctrl.set_status) begin
      status_code <= ctrl.status;
      conflict    <= ctrl.idx_from_eval ? eval_idx : '0;
    end
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (ctrl.op == prt_pkg::OP_RESPOND) begin
      result <= '{status:         status_code,
                  conflict_index: prt_pkg::idx_t'(conflict),
                  regions_used:   prt_pkg::used_t'(reg_count)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.op == prt_pkg::OP_RESPOND);
    end
  end

endmodule

### hw/rtl/prt_checker.sv
// Port-level checks for the protected region table, bound to the top level.
// Depends on prt_pkg and protected_region_table_top_defines.svh.
`timescale 1ns / 1ps
`include "protected_region_table_top_defines.svh"

module prt_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input prt_pkg::request_t request,
  input logic              busy,
  input logic              done,
  input prt_pkg::result_t  result
);

  logic accepted;
  logic idx_expected;

  assign accepted     = start && !busy;
  assign idx_expected = (result.status == prt_pkg::ST_RESERVED) ||
                        (result.status == prt_pkg::ST_OVERLAP);

  // A result is shown only once the block is ready for the next command.
  `PRT_ASSERT_SAME(a_done_not_busy, done, !busy, "result strobe while busy")
  // An accepted command keeps the block busy and gives no result at once.
  `PRT_ASSERT_NEXT(a_accept_busy, accepted, busy && !done, "accept not followed by busy")
  // The region count never exceeds the table size.
  `PRT_ASSERT_SAME(a_used_bound, done,
      result.regions_used <= prt_pkg::used_t'(prt_pkg::MAX_REGION_ENTRIES),
      "region count beyond table size")
  // Only conflict results carry an index.
  `PRT_ASSERT_SAME(a_idx_zero, done && !idx_expected, result.conflict_index == '0,
      "conflict index set without a conflict")

endmodule

bind protected_region_table_top prt_checker u_prt_checker (.*);
